FILE: design/bcmf_pkg.sv
package bcmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_RADIUS = 3;
   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int SLOT_BITS  = $clog2(STORE_ROWS);
   localparam int ADDR_BITS  = SLOT_BITS + COL_BITS;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam logic [1:0]  RADIUS_RESET = 2'd1;
   localparam logic [10:0] WIDTH_CAP    = 11'(MAX_WIDTH);
   localparam logic [12:0] HEIGHT_CAP   = 13'd4096;

   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_WINDOW_RADIUS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CENTER,
      ST_BIT,
      ST_PASS,
      ST_DRAIN,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic center_init;
      logic bit_init;
      logic step;
      logic bit_done;
      logic next_center;
   } cmd_type;

   typedef struct packed {
      logic has_centers;
      logic win_last;
      logic bit_last;
      logic center_last;
   } status_type;

   function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS-1:0] r;
      if (s == SLOT_BITS'(STORE_ROWS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_BITS'(1);
      end
      return r;
   endfunction

   function automatic logic [SLOT_BITS-1:0] slot_back(input logic [SLOT_BITS-1:0] s,
                                                      input logic [1:0] d);
      logic [SLOT_BITS:0] t;
      t = {1'b0, s} + (SLOT_BITS+1)'(STORE_ROWS) - {{(SLOT_BITS-1){1'b0}}, d};
      if (t >= (SLOT_BITS+1)'(STORE_ROWS)) begin
         t = t - (SLOT_BITS+1)'(STORE_ROWS);
      end
      return t[SLOT_BITS-1:0];
   endfunction

endpackage

FILE: design/bcmf_req_if.sv
interface bcmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

FILE: design/bcmf_rsp_if.sv
interface bcmf_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] center_row;
   logic [9:0]  center_column;
   logic [7:0]  median_value;
   logic        last_of_run;

   modport source (output valid, output center_row, output center_column,
                   output median_value, output last_of_run, input ready);
   modport sink (input valid, input center_row, input center_column,
                 input median_value, input last_of_run, output ready);
endinterface

FILE: design/bcmf_controller.sv
module bcmf_controller
   import bcmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.has_centers ? ST_CENTER : ST_IDLE;
         end
         ST_CENTER: begin
            cmd.center_init = 1'b1;
            state_in        = ST_BIT;
         end
         ST_BIT: begin
            cmd.bit_init = 1'b1;
            state_in     = ST_PASS;
         end
         ST_PASS: begin
            cmd.step = 1'b1;
            if (status.win_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.bit_done = 1'b1;
            state_in     = status.bit_last ? ST_OUT : ST_BIT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.next_center = 1'b1;
               state_in        = status.center_last ? ST_IDLE : ST_CENTER;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/bcmf_datapath.sv
module bcmf_datapath
   import bcmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data,
   input  logic [7:0]  pixel_value,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [11:0] center_row,
   output logic [9:0]  center_column,
   output logic [7:0]  median_value,
   output logic        last_of_run
);

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [1:0]  radius_ff;
   logic [11:0] row_ff;
   logic [COL_BITS-1:0]  col_ff;
   logic [SLOT_BITS-1:0] slot_ff;

   logic [7:0] store_mem [STORE_DEPTH];

   logic [11:0] cy_ff;
   logic [11:0] cy_hi_ff;
   logic [COL_BITS-1:0] cx_ff;
   logic [COL_BITS-1:0] cx_lo_ff;
   logic [COL_BITS-1:0] cx_hi_ff;
   logic [SLOT_BITS-1:0] cslot_ff;
   logic has_ff;

   logic [SLOT_BITS-1:0] wslot_lo_ff;
   logic [COL_BITS-1:0]  wx_lo_ff;
   logic [COL_BITS-1:0]  wx_hi_ff;
   logic [2:0] nrows_ff;
   logic [5:0] k_ff;
   logic [7:0] prefix_ff;
   logic [2:0] bit_ff;

   logic [SLOT_BITS-1:0] ws_ff;
   logic [COL_BITS-1:0]  wx_ff;
   logic [2:0] rc_ff;
   logic [5:0] cnt_ff;
   logic [7:0] rd_ff;
   logic       rdv_ff;

   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [12:0] r13;
   logic [10:0] r11;

   logic [12:0] r0;
   logic [10:0] c0;
   logic [SLOT_BITS-1:0] s0;
   logic [12:0] r1;
   logic [10:0] c1;
   logic [SLOT_BITS-1:0] s1;
   logic [12:0] ylo_a;
   logic [12:0] yhi_a;
   logic [10:0] xlo_a;
   logic [10:0] xhi_a;
   logic has_a;
   logic [12:0] dy_a;

   logic [12:0] cy13;
   logic [12:0] ytop;
   logic [12:0] wylo;
   logic [12:0] wyhi;
   logic [10:0] cx11;
   logic [10:0] xtop;
   logic [10:0] wxlo;
   logic [10:0] wxhi;
   logic [12:0] nrows_w;
   logic [10:0] ncols_w;
   logic [5:0]  n_win;
   logic [12:0] dyw;

   logic [8:0] mask9;
   logic       match;

   assign w_eff = (width_ff == 11'd0) ? 11'd1 : ((width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff);
   assign h_eff = (height_ff == 13'd0) ? 13'd1 :
                  ((height_ff > HEIGHT_CAP) ? HEIGHT_CAP : height_ff);
   assign r13 = {11'd0, radius_ff};
   assign r11 = {9'd0, radius_ff};

   always_comb begin
      c0 = {1'b0, col_ff};
      r0 = {1'b0, row_ff};
      s0 = slot_ff;
      if (c0 >= w_eff) begin
         c0 = '0;
         r0 = r0 + 13'd1;
         s0 = slot_inc(s0);
      end
      if (r0 >= h_eff) begin
         r0 = '0;
         s0 = '0;
      end
      c1 = c0 + 11'd1;
      r1 = r0;
      s1 = s0;
      if (c1 >= w_eff) begin
         c1 = '0;
         r1 = r0 + 13'd1;
         s1 = slot_inc(s0);
         if (r1 >= h_eff) begin
            r1 = '0;
            s1 = '0;
         end
      end
      ylo_a = (r0 >= r13) ? r0 - r13 : 13'd0;
      yhi_a = (r0 + 13'd1 == h_eff) ? r0 : ylo_a;
      xlo_a = (c0 >= r11) ? c0 - r11 : 11'd0;
      xhi_a = (c0 + 11'd1 == w_eff) ? c0 : xlo_a;
      has_a = ((r0 + 13'd1 == h_eff) || (r0 >= r13)) &&
              ((c0 + 11'd1 == w_eff) || (c0 >= r11));
      dy_a  = r0 - ylo_a;
   end

   always_comb begin
      cy13 = {1'b0, cy_ff};
      ytop = cy13 + r13;
      wylo = (cy13 >= r13) ? cy13 - r13 : 13'd0;
      wyhi = (ytop >= h_eff) ? h_eff - 13'd1 : ytop;
      cx11 = {1'b0, cx_ff};
      xtop = cx11 + r11;
      wxlo = (cx11 >= r11) ? cx11 - r11 : 11'd0;
      wxhi = (xtop >= w_eff) ? w_eff - 11'd1 : xtop;
      nrows_w = wyhi - wylo + 13'd1;
      ncols_w = wxhi - wxlo + 11'd1;
      n_win = {3'd0, nrows_w[2:0]} * {3'd0, ncols_w[2:0]};
      dyw = cy13 - wylo;
   end

   assign mask9 = 9'h1FE << bit_ff;
   assign match = (((rd_ff ^ prefix_ff) & mask9[7:0]) == 8'd0) && !rd_ff[bit_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data[10:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data;
            CSR_WINDOW_RADIUS: radius_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
         has_ff  <= 1'b0;
         rdv_ff  <= 1'b0;
      end else begin
         rdv_ff <= cmd.step;
         if (cmd.accept) begin
            row_ff  <= r1[11:0];
            col_ff  <= c1[COL_BITS-1:0];
            slot_ff <= s1;
            has_ff  <= has_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[{s0, c0[COL_BITS-1:0]}] <= pixel_value;
      end
      if (cmd.step) begin
         rd_ff <= store_mem[{ws_ff, wx_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cy_ff    <= ylo_a[11:0];
         cy_hi_ff <= yhi_a[11:0];
         cx_ff    <= xlo_a[COL_BITS-1:0];
         cx_lo_ff <= xlo_a[COL_BITS-1:0];
         cx_hi_ff <= xhi_a[COL_BITS-1:0];
         cslot_ff <= slot_back(s0, dy_a[1:0]);
      end else if (cmd.next_center) begin
         if (cx_ff == cx_hi_ff) begin
            cx_ff    <= cx_lo_ff;
            cy_ff    <= cy_ff + 12'd1;
            cslot_ff <= slot_inc(cslot_ff);
         end else begin
            cx_ff <= cx_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.center_init) begin
         wslot_lo_ff <= slot_back(cslot_ff, dyw[1:0]);
         wx_lo_ff    <= wxlo[COL_BITS-1:0];
         wx_hi_ff    <= wxhi[COL_BITS-1:0];
         nrows_ff    <= nrows_w[2:0];
         k_ff        <= {1'b0, n_win[5:1]};
         prefix_ff   <= '0;
         bit_ff      <= 3'd7;
      end else if (cmd.bit_done) begin
         if (cnt_ff <= k_ff) begin
            prefix_ff[bit_ff] <= 1'b1;
            k_ff <= k_ff - cnt_ff;
         end
         bit_ff <= bit_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bit_init) begin
         ws_ff  <= wslot_lo_ff;
         wx_ff  <= wx_lo_ff;
         rc_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.step) begin
            if (wx_ff == wx_hi_ff) begin
               wx_ff <= wx_lo_ff;
               ws_ff <= slot_inc(ws_ff);
               rc_ff <= rc_ff + 3'd1;
            end else begin
               wx_ff <= wx_ff + COL_BITS'(1);
            end
         end
         if (rdv_ff && match) begin
            cnt_ff <= cnt_ff + 6'd1;
         end
      end
   end

   assign status.has_centers = has_ff;
   assign status.win_last    = (wx_ff == wx_hi_ff) && (rc_ff == nrows_ff - 3'd1);
   assign status.bit_last    = (bit_ff == 3'd0);
   assign status.center_last = (cy_ff == cy_hi_ff) && (cx_ff == cx_hi_ff);

   assign center_row    = cy_ff;
   assign center_column = cx_ff;
   assign median_value  = prefix_ff;
   assign last_of_run   = status.center_last;

endmodule

FILE: design/border_cropping_median_filter_top.sv
// A pixel that completes no window passes through the check state and then returns to idle.
// Each median comes from eight bit-select passes, each with one line-store read per element
// of the clipped window, which holds up to 49 elements.
// Results of one pixel follow each other; the next pixel is taken after the last one.
// Reset is synchronous and active high; it clears positions and restores the registers.
module border_cropping_median_filter_top
   import bcmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bcmf_req_if.sink    req_channel,
   bcmf_rsp_if.source  rsp_channel,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   bcmf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcmf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pixel_value      (req_channel.pixel_value),
      .cmd              (cmd),
      .status           (status),
      .center_row       (rsp_channel.center_row),
      .center_column    (rsp_channel.center_column),
      .median_value     (rsp_channel.median_value),
      .last_of_run      (rsp_channel.last_of_run)
   );

endmodule

FILE: design/bcmf_checker.sv
module bcmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] center_row,
   input logic [9:0]  center_column,
   input logic [7:0]  median_value,
   input logic        last_of_run
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(center_row) &&
      $stable(center_column) && $stable(median_value) && $stable(last_of_run))
      else $error("Result changed while stalled.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Input taken while a result is pending.");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input ready right after a transfer.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind border_cropping_median_filter_top bcmf_checker u_bcmf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_channel.valid),
   .req_ready     (req_channel.ready),
   .rsp_valid     (rsp_channel.valid),
   .rsp_ready     (rsp_channel.ready),
   .center_row    (rsp_channel.center_row),
   .center_column (rsp_channel.center_column),
   .median_value  (rsp_channel.median_value),
   .last_of_run   (rsp_channel.last_of_run)
);
